// ----- sv/clt_pkg.sv -----
package clt_pkg;

    localparam int CLT_TEXT_MAX_DEFAULT = 16;
    localparam int CLT_TEXT_DEPTH = 16;
    localparam int CLT_KW_COUNT = 9;
    localparam int CLT_KW_MAXLEN = 6;

    typedef enum logic [2:0] {
        KIND_EOL = 3'd0,
        KIND_ID  = 3'd1,
        KIND_KW  = 3'd2,
        KIND_INT = 3'd3,
        KIND_STR = 3'd4,
        KIND_ERR = 3'd5
    } kind_t;

    typedef logic [CLT_TEXT_DEPTH-1:0][7:0] text_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         keyword_index;
        logic signed [31:0] int_value;
        logic               int_overflow;
        logic [4:0]         text_len;
        logic [63:0]        text_lo;
        logic [63:0]        text_hi;
        logic               text_truncated;
        logic               last_of_run;
    } clt_result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } kw_hit_t;

    // keyword spellings, padded with zero bytes
    localparam logic [7:0] KW_CHARS [CLT_KW_COUNT][CLT_KW_MAXLEN] = '{
        '{"s", "p", "i", "w", 8'h00, 8'h00},
        '{"e", "r", "a", "s", "e", 8'h00},
        '{"c", "o", "n", "f", "i", "g"},
        '{"r", "e", "a", "d", 8'h00, 8'h00},
        '{"r", "e", "d", "r", "a", "w"},
        '{"l", "m", "x", 8'h00, 8'h00, 8'h00},
        '{"p", "r", "o", "g", 8'h00, 8'h00},
        '{"w", "r", "i", "t", "e", 8'h00},
        '{"r", "e", "g", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [4:0] KW_LEN [CLT_KW_COUNT] = '{
        5'd4, 5'd5, 5'd6, 5'd4, 5'd6, 5'd3, 5'd4, 5'd5, 5'd3
    };

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // case-blind compare against all keywords, lowest index wins
    function automatic kw_hit_t kw_match(input text_t s, input logic [4:0] len);
        kw_hit_t r;
        logic    ok;
        r = '0;
        for (int k = CLT_KW_COUNT - 1; k >= 0; k--)
        begin
            ok = (len == KW_LEN[k]);
            for (int j = 0; j < CLT_KW_MAXLEN; j++)
            begin
                if (5'(j) < KW_LEN[k] && to_lower(s[j]) != KW_CHARS[k][j])
                    ok = 1'b0;
            end
            if (ok)
            begin
                r.hit   = 1'b1;
                r.index = 4'(k);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/clt_lexer.sv -----
module clt_lexer
    import clt_pkg::*;
#(
    parameter int TEXT_MAX = CLT_TEXT_MAX_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            char_in,
    input  logic                  buffer_end,
    output clt_result_t [2:0]     res,
    output logic [1:0]            res_n
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_MINUS, M_STRING, M_ESC, M_HEX1, M_HEX2, M_AFTER_CR
    } mode_t;

    typedef enum logic [3:0] {
        E_EOL, E_OLD_ID, E_OLD_INT, E_OLD_ERR, E_OLD_STR, E_NEW_ID, E_NEW_INT, E_NEW_ERR,
        E_DASH
    } emit_t;

    typedef struct packed {
        text_t      s;
        logic [4:0] n;
        logic       t;
    } push_t;

    mode_t       mode_reg, mode_next;
    text_t       store_reg, store_next;
    logic [4:0]  count_reg, count_next;
    logic        trunc_reg, trunc_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic [3:0]  hex_reg, hex_next;
    emit_t       code [3];

    function automatic push_t push_char(input text_t s, input logic [4:0] n, input logic t,
                                        input logic [7:0] c);
        push_t r;
        r = '{s: s, n: n, t: t};
        if (n < 5'(TEXT_MAX))
        begin
            r.s[n[3:0]] = c;
            r.n = n + 5'd1;
        end
        else
            r.t = 1'b1;
        return r;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c[3:0];
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic clt_result_t tok_result(input kind_t k, input text_t s,
                                               input logic [4:0] len, input logic t,
                                               input logic [31:0] acc, input logic neg,
                                               input logic ovf);
        clt_result_t r;
        kw_hit_t     h;
        r = '0;
        r.kind = k;
        if (k == KIND_INT)
        begin
            r.int_value    = neg ? 32'd0 - acc : acc;
            r.int_overflow = ovf || (!neg && acc == 32'h8000_0000);
        end
        else
        begin
            r.text_len       = len;
            r.text_truncated = t;
            for (int i = 0; i < 8; i++)
            begin
                r.text_lo[8*i +: 8] = (5'(i) < len) ? s[i] : 8'h00;
                r.text_hi[8*i +: 8] = (5'(i + 8) < len) ? s[i+8] : 8'h00;
            end
            h = kw_match(s, len);
            if (k == KIND_ID && !t && h.hit)
            begin
                r.kind          = KIND_KW;
                r.keyword_index = h.index;
            end
        end
        return r;
    endfunction

    // next state and ordered list of emitted tokens
    always_comb
    begin
        push_t       p;
        logic        do_idle;
        logic        line_done;
        logic        is_alpha;
        logic        is_digit;
        logic        is_eol;
        logic [35:0] mul;
        logic        cv [4];
        emit_t       cc [4];
        logic [1:0]  n_v;

        mode_next  = mode_reg;
        store_next = store_reg;
        count_next = count_reg;
        trunc_next = trunc_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        hex_next   = hex_reg;
        do_idle    = 1'b0;
        line_done  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            cv[i] = 1'b0;
            cc[i] = E_EOL;
        end
        is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
        is_digit = (char_in >= "0" && char_in <= "9");
        is_eol   = (char_in == 8'h0a) || (char_in == 8'h0d) || (char_in == 8'h00);
        mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, char_in[3:0]};
        p = push_char(store_reg, count_reg, trunc_reg, char_in);

        // close or continue the open token
        case (mode_reg)
            M_IDENT:
                if (is_alpha || is_digit || char_in == "_")
                begin
                    store_next = p.s; count_next = p.n; trunc_next = p.t;
                end
                else
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_ID; do_idle = 1'b1;
                end
            M_NUMBER, M_MINUS:
                if (is_digit)
                begin
                    acc_next  = mul[31:0];
                    mode_next = M_NUMBER;
                    if (mul > 36'h0_8000_0000)
                        ovf_next = 1'b1;
                end
                else
                begin
                    cv[0] = 1'b1;
                    cc[0] = (mode_reg == M_NUMBER) ? E_OLD_INT : E_DASH;
                    do_idle = 1'b1;
                end
            M_STRING:
                if (is_eol)
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_ERR; do_idle = 1'b1;
                end
                else if (char_in == "\"")
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_STR; mode_next = M_IDLE;
                end
                else if (char_in == "\\")
                    mode_next = M_ESC;
                else
                begin
                    store_next = p.s; count_next = p.n; trunc_next = p.t;
                end
            M_ESC:
                if (is_eol)
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_ERR; do_idle = 1'b1;
                end
                else
                begin
                    mode_next = M_STRING;
                    if (char_in == "\"" || char_in == "\\")
                        p = push_char(store_reg, count_reg, trunc_reg, char_in);
                    else if (char_in == "n")
                        p = push_char(store_reg, count_reg, trunc_reg, 8'h0a);
                    else if (char_in == "r")
                        p = push_char(store_reg, count_reg, trunc_reg, 8'h0d);
                    else if (char_in == "t")
                        p = push_char(store_reg, count_reg, trunc_reg, 8'h09);
                    else
                        p = '{s: store_reg, n: count_reg, t: trunc_reg};
                    store_next = p.s; count_next = p.n; trunc_next = p.t;
                    if (char_in == "x")
                        mode_next = M_HEX1;
                end
            M_HEX1:
                if (is_eol)
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_ERR; do_idle = 1'b1;
                end
                else
                begin
                    hex_next  = hex_value(char_in);
                    mode_next = M_HEX2;
                end
            M_HEX2:
                if (is_eol)
                begin
                    cv[0] = 1'b1; cc[0] = E_OLD_ERR; do_idle = 1'b1;
                end
                else
                begin
                    p = push_char(store_reg, count_reg, trunc_reg,
                                  {hex_reg, hex_value(char_in)});
                    store_next = p.s; count_next = p.n; trunc_next = p.t;
                    mode_next  = M_STRING;
                end
            M_AFTER_CR:
            begin
                mode_next = M_IDLE;
                if (char_in == 8'h0a)
                    line_done = 1'b1;
                else
                    do_idle = 1'b1;
            end
            default:
                do_idle = 1'b1;
        endcase

        // byte handled between tokens
        if (do_idle)
        begin
            mode_next = M_IDLE;
            if (!(char_in == 8'h20 || char_in == 8'h09 || char_in == 8'h0b ||
                  char_in == 8'h0c))
            begin
                if (is_eol)
                begin
                    cv[1] = 1'b1; cc[1] = E_EOL; line_done = 1'b1;
                    if (char_in == 8'h0d)
                        mode_next = M_AFTER_CR;
                end
                else
                begin
                    count_next = 5'd0;
                    trunc_next = 1'b0;
                    acc_next   = 32'd0;
                    neg_next   = 1'b0;
                    ovf_next   = 1'b0;
                    hex_next   = 4'd0;
                    if (is_alpha || char_in == "_" || is_digit || char_in == "-" ||
                        char_in == "\"")
                    begin
                        if (is_alpha || char_in == "_")
                        begin
                            store_next[0] = char_in; count_next = 5'd1;
                            mode_next = M_IDENT;
                        end
                        else if (is_digit)
                        begin
                            acc_next = {28'd0, char_in[3:0]}; mode_next = M_NUMBER;
                        end
                        else if (char_in == "-")
                        begin
                            neg_next = 1'b1; mode_next = M_MINUS;
                        end
                        else
                            mode_next = M_STRING;
                    end
                    else
                    begin
                        store_next[0] = char_in; count_next = 5'd1;
                        cv[1] = 1'b1; cc[1] = E_NEW_ERR;
                    end
                end
            end
        end

        // end of buffer closes the line
        if (buffer_end)
        begin
            if (!line_done)
            begin
                case (mode_next)
                    M_IDENT:  begin cv[2] = 1'b1; cc[2] = E_NEW_ID; end
                    M_NUMBER: begin cv[2] = 1'b1; cc[2] = E_NEW_INT; end
                    M_MINUS:  begin cv[2] = 1'b1; cc[2] = E_DASH; end
                    M_STRING, M_ESC, M_HEX1, M_HEX2:
                              begin cv[2] = 1'b1; cc[2] = E_NEW_ERR; end
                    default: ;
                endcase
                cv[3] = 1'b1; cc[3] = E_EOL;
            end
            mode_next = M_IDLE;
        end

        // pack the emitted tokens in order
        n_v = 2'd0;
        for (int i = 0; i < 3; i++)
            code[i] = E_EOL;
        for (int i = 0; i < 4; i++)
        begin
            if (cv[i] && n_v != 2'd3)
            begin
                code[n_v] = cc[i];
                n_v = n_v + 2'd1;
            end
        end
        res_n = n_v;
    end

    // token result per slot
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (code[i])
                E_OLD_ID:  res[i] = tok_result(KIND_ID, store_reg, count_reg, trunc_reg,
                                               acc_reg, neg_reg, ovf_reg);
                E_OLD_INT: res[i] = tok_result(KIND_INT, store_reg, count_reg, trunc_reg,
                                               acc_reg, neg_reg, ovf_reg);
                E_OLD_ERR: res[i] = tok_result(KIND_ERR, store_reg, count_reg, trunc_reg,
                                               acc_reg, neg_reg, ovf_reg);
                E_OLD_STR: res[i] = tok_result(KIND_STR, store_reg, count_reg, trunc_reg,
                                               acc_reg, neg_reg, ovf_reg);
                E_NEW_ID:  res[i] = tok_result(KIND_ID, store_next, count_next, trunc_next,
                                               acc_next, neg_next, ovf_next);
                E_NEW_INT: res[i] = tok_result(KIND_INT, store_next, count_next, trunc_next,
                                               acc_next, neg_next, ovf_next);
                E_NEW_ERR: res[i] = tok_result(KIND_ERR, store_next, count_next, trunc_next,
                                               acc_next, neg_next, ovf_next);
                E_DASH:
                begin
                    res[i] = '0;
                    res[i].kind     = KIND_ERR;
                    res[i].text_len = 5'd1;
                    res[i].text_lo  = 64'h2d;
                end
                default:   res[i] = '0;
            endcase
            res[i].last_of_run = (2'(i + 1) == res_n);
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            count_reg <= 5'd0;
            trunc_reg <= 1'b0;
            acc_reg   <= 32'd0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            hex_reg   <= 4'd0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            trunc_reg <= trunc_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            hex_reg   <= hex_next;
        end
    end

    // text bytes, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
            store_reg <= store_next;
    end

endmodule

// ----- sv/clt_outq.sv -----
module clt_outq
    import clt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  clt_result_t [2:0] res,
    input  logic [1:0]        res_n,
    input  logic              out_stall,
    output clt_result_t       head,
    output logic              out_valid,
    output logic              can_load
);

    clt_result_t [2:0] q_reg;
    logic [1:0]        cnt_reg;
    logic              out_fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_fire  = out_valid && !out_stall;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_fire);
    assign head      = q_reg[0];

    // result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res_n;
        else if (out_fire)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // result slots, shifted towards the head
    always_ff @(posedge clk)
    begin
        if (load)
            q_reg <= res;
        else if (out_fire)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

endmodule

// ----- sv/command_line_tokenizer_core.sv -----
// command line tokenizer
// input channel: one console byte per transaction (char_in, buffer_end),
// accepted when in_valid is high and in_stall low
// output channel: one token per transaction (kind, keyword_index, int_value,
// int_overflow, text_len, text_lo, text_hi, text_truncated, last_of_run)
// each byte yields zero to three tokens; last_of_run marks the final one
// the byte is scanned in the cycle it is accepted and its tokens sit in a
// three-slot result queue from the next cycle
// throughput: one byte per cycle while each byte yields at most one token and
// the receiver does not stall; a byte with several tokens stalls the input until
// its last token is being delivered, as the single output port drains the queue
// a new byte is taken while the last queued token is being delivered
// when the receiver stalls the head token holds and the input stalls while
// any token is queued
// reset empties the queue and returns the scanner to idle between tokens
module command_line_tokenizer_core
    import clt_pkg::*;
#(
    parameter int TEXT_MAX = CLT_TEXT_MAX_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_in,
    input  logic               buffer_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [3:0]         keyword_index,
    output logic signed [31:0] int_value,
    output logic               int_overflow,
    output logic [4:0]         text_len,
    output logic [63:0]        text_lo,
    output logic [63:0]        text_hi,
    output logic               text_truncated,
    output logic               last_of_run
);

    clt_result_t [2:0] res;
    logic [1:0]        res_n;
    clt_result_t       head;
    logic              can_load;
    logic              fire;

    assign in_stall = !can_load;
    assign fire     = in_valid && can_load;

    clt_lexer #(.TEXT_MAX(TEXT_MAX)) u_lexer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .char_in    (char_in),
        .buffer_end (buffer_end),
        .res        (res),
        .res_n      (res_n)
    );

    clt_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .res_n     (res_n),
        .out_stall (out_stall),
        .head      (head),
        .out_valid (out_valid),
        .can_load  (can_load)
    );

    // result fields
    assign kind           = head.kind;
    assign keyword_index  = head.keyword_index;
    assign int_value      = head.int_value;
    assign int_overflow   = head.int_overflow;
    assign text_len       = head.text_len;
    assign text_lo        = head.text_lo;
    assign text_hi        = head.text_hi;
    assign text_truncated = head.text_truncated;
    assign last_of_run    = head.last_of_run;

endmodule

// ----- sv/clt_checker.sv -----
module clt_checker
    import clt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         kind,
    input logic [3:0]         keyword_index,
    input logic signed [31:0] int_value,
    input logic [4:0]         text_len
);

    // a stalled token holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(int_value))
        else $error("stalled token changed");

    // an empty queue always takes a byte
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with nothing queued");

    // end of line carries nothing
    a_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EOL |-> text_len == 5'd0 && int_value == 32'sd0)
        else $error("end of line token carries data");

    // keyword index only on keywords
    a_kwi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_KW |-> keyword_index == 4'd0)
        else $error("keyword index on non-keyword token");

endmodule

bind command_line_tokenizer_core clt_checker u_clt_checker (.*);
